>>> design/brm_pkg.sv
// ----------------------------------------------------------------------------
// brm_pkg: shared constants and helpers for the beat interval rate meter
// Ring geometry, field widths, register indexes and the slot step-back helper.
// ----------------------------------------------------------------------------
package brm_pkg;

  // Number of beats that can be counted; the ring holds one more stamp.
  localparam int DEPTH  = 31;
  localparam int RING   = DEPTH + 1;
  localparam int SLOT_W = $clog2(RING);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths.
  localparam int STAMP_W = 32;
  localparam int REG_W   = 16;
  localparam int RATE_W  = 20;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 24;

  // Accumulated history stays below window plus one gap limit.
  localparam int SUM_W = REG_W + 1;

  // Numerator of the rate division: count times one million.
  localparam int MILLION_W = 20;
  localparam int NUM_W     = CNT_W + MILLION_W;
  localparam int STEP_W    = $clog2(NUM_W);

  localparam logic [MILLION_W-1:0] MILLION  = MILLION_W'(1000000);
  localparam logic [RATE_W-1:0]    RATE_MAX = RATE_W'(1000000);

  // Item kinds carried on tuser.
  localparam logic KIND_BEAT  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_GAP    = 1'b1;

  // Previous slot in the ring, wrapping from the first slot to the last.
  function automatic logic [SLOT_W-1:0] slot_before(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (slot == '0) begin
      res = SLOT_W'(DEPTH);
    end else begin
      res = slot - SLOT_W'(1);
    end
    return res;
  endfunction

endpackage

>>> design/brm_div.sv
// ----------------------------------------------------------------------------
// brm_div: bit-serial restoring divider
// Produces one quotient bit per cycle; done pulses with the quotient valid.
// ----------------------------------------------------------------------------
module brm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [brm_pkg::NUM_W-1:0]   num,
  input  logic [brm_pkg::SUM_W-1:0]   den,
  output logic                        done,
  output logic [brm_pkg::NUM_W-1:0]   quo
);
  import brm_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   cnt;
  logic [SUM_W-1:0]    rem;
  logic [NUM_W-1:0]    nq;
  logic [SUM_W:0]      trial;
  logic                fits;

  // Shift the next numerator bit into the partial remainder and try the divisor.
  assign trial = {rem, nq[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});
  assign quo   = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(NUM_W - 1);
        rem  <= '0;
        nq   <= num;
      end else if (busy) begin
        if (fits) begin
          rem <= SUM_W'(trial - {1'b0, den});
        end else begin
          rem <= trial[SUM_W-1:0];
        end
        nq <= {nq[NUM_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - STEP_W'(1);
        end
      end
    end
  end

endmodule

>>> design/beat_interval_rate_meter.sv
// ----------------------------------------------------------------------------
// beat_interval_rate_meter: beat rate from averaged beat-to-beat intervals
// Stores beat timestamps in a ring, walks back over recent intervals and
// divides the interval count by the summed history to give millihertz.
// ----------------------------------------------------------------------------
//
//   Channel   | Direction | Contents
//   ----------+-----------+----------------------------------------------------
//   s_*       | in        | tuser: kind; tdata: timestamp_ms
//   m_*       | out       | tdata: rate_mhz, zero-padded to 24 bits
//   cfg_*     | in        | register 0 window_ms, register 1 gap_limit_ms
//
// A beat request walks back over the stored intervals, each step one ring read
// and then one compare and add, until a check ends the walk; it then passes
// through the multiply, the divider stage (start, one quotient bit per cycle,
// done) and the load of the output register. The single ring read port and
// the divider set how long a request takes. A clear request goes straight to
// the output register load, and a walk that counts no interval or sums to zero
// skips the multiply and the divider. Reset is synchronous and needs no
// clearing pass, since the walk only reaches ring entries written since the
// last clear.
// The input side is ready only while the sequencer is idle; a finished result
// waits in the output register while the next request is already accepted.
//
module beat_interval_rate_meter (
  input  logic                              clk,
  input  logic                              rst,
  // Input requests.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [brm_pkg::TDATA_IN_W-1:0]    s_tdata,   // [31:0] timestamp_ms
  input  logic                              s_tuser,   // [0] kind
  // Results.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [brm_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [19:0] rate_mhz, rest zero
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [brm_pkg::REG_W-1:0]         cfg_data
);
  import brm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_STEP,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;

  logic [REG_W-1:0]   window_ms;
  logic [REG_W-1:0]   gap_limit_ms;

  // Ring of timestamps; entries are undefined until written.
  logic [STAMP_W-1:0] ring [RING];
  logic [STAMP_W-1:0] rd_data;

  logic [SLOT_W-1:0]  write_slot;
  logic [CNT_W-1:0]   beats_stored;
  logic [SLOT_W-1:0]  cur_slot;
  logic [SLOT_W-1:0]  older_slot;
  logic [STAMP_W-1:0] cur_stamp;
  logic [CNT_W-1:0]   count;
  logic [SUM_W-1:0]   sum;
  logic [NUM_W-1:0]   num;

  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;

  logic               accept;
  logic               more;
  logic [STAMP_W-1:0] diff;
  logic               too_long;
  state_t             after_walk;
  logic [RATE_W-1:0]  rate;

  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == S_IDLE);
  assign older_slot = slot_before(cur_slot);

  // The walk goes on while the summed history is short of the window and an
  // older stored beat remains.
  assign more = (sum < SUM_W'(window_ms)) &&
                (({1'b0, count} + (CNT_W+1)'(1)) < {1'b0, beats_stored});

  // Interval from the older beat to the current one, modulo 2^32.
  assign diff     = cur_stamp - rd_data;
  assign too_long = (diff > STAMP_W'(gap_limit_ms));

  // With no interval, or intervals summing to zero, the divider is skipped.
  assign after_walk = ((count == '0) || (sum == '0)) ? S_FIN : S_MUL;

  always_comb begin
    if (count == '0) begin
      rate = '0;
    end else if (sum == '0) begin
      rate = RATE_MAX;
    end else if (div_quo > NUM_W'(RATE_MAX)) begin
      rate = RATE_MAX;
    end else begin
      rate = div_quo[RATE_W-1:0];
    end
  end

  // Ring storage: written on an accepted beat, read at the slot behind the
  // walk position every cycle.
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == KIND_BEAT)) begin
      ring[write_slot] <= s_tdata;
    end
    rd_data <= ring[older_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms    <= REG_W'(5000);
      gap_limit_ms <= REG_W'(2500);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW: window_ms    <= cfg_data;
        CFG_GAP:    gap_limit_ms <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      write_slot   <= '0;
      beats_stored <= '0;
      count        <= '0;
      sum          <= '0;
      div_start    <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
    end else begin
      div_start <= 1'b0;
      // In S_FIN a result taken at this edge is replaced by the new one there.
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count <= '0;
            sum   <= '0;
            if (s_tuser == KIND_CLEAR) begin
              write_slot   <= '0;
              beats_stored <= '0;
              state        <= S_FIN;
            end else begin
              write_slot <= (write_slot >= SLOT_W'(DEPTH)) ? '0 : write_slot + SLOT_W'(1);
              if (beats_stored < CNT_W'(DEPTH)) begin
                beats_stored <= beats_stored + CNT_W'(1);
              end
              cur_slot  <= write_slot;
              cur_stamp <= s_tdata;
              state     <= S_WALK;
            end
          end
        end

        S_WALK: begin
          // The ring read of the older slot is registered into rd_data here, ready for S_STEP.
          state <= more ? S_STEP : after_walk;
        end

        S_STEP: begin
          if (too_long) begin
            state <= after_walk;
          end else begin
            sum       <= sum + diff[SUM_W-1:0];
            cur_stamp <= rd_data;
            cur_slot  <= older_slot;
            count     <= count + CNT_W'(1);
            state     <= S_WALK;
          end
        end

        S_MUL: begin
          num       <= NUM_W'(count) * NUM_W'(MILLION);
          div_start <= 1'b1;
          state     <= S_DIV;
        end

        S_DIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= TDATA_OUT_W'(rate);
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  brm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (sum),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

>>> design/brm_checker.sv
// ----------------------------------------------------------------------------
// brm_checker: port-level checks for the beat interval rate meter
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module brm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [brm_pkg::TDATA_OUT_W-1:0]   m_tdata
);
  import brm_pkg::*;

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed or dropped while stalled");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted request");

  // The rate never passes its saturation value and the padding stays zero.
  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[RATE_W-1:0] <= RATE_MAX) &&
                  (m_tdata[TDATA_OUT_W-1:RATE_W] == '0)))
    else $error("rate out of range");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind beat_interval_rate_meter brm_checker u_brm_checker (.*);
